// ===== rtl/lpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfr_pkg: shared types and constants of the length-prefixed frame receiver
// Frame control bytes, buffer sizing, operation codes and channel payloads.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  // Frame buffer sizing
  localparam int BUFFER_DEPTH = 512;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);

  // Line control bytes
  localparam logic [7:0] SOH = 8'h01;
  localparam logic [7:0] EOT = 8'h04;
  localparam logic [7:0] ACK = 8'h06;
  localparam logic [7:0] NAK = 8'h15;

  // Operation codes of an input transaction
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Input transaction payload
  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic [8:0] read_index;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic        kind;
    logic [7:0]  reply_byte;
    logic        frame_accepted;
    logic [15:0] frame_length;
    logic [7:0]  read_data;
  } out_item_t;

  // Result of one accepted item, before the buffer read data joins it
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  reply_byte;
    logic        frame_accepted;
    logic [15:0] frame_length;
    logic        in_range;
  } res_t;

endpackage

// ===== rtl/lpfr_in_if.sv =====
// ----------------------------------------------------------------------------
// lpfr_in_if: input channel
// Valid/ready channel carrying serial bytes and buffer read requests.
// ----------------------------------------------------------------------------
interface lpfr_in_if import lpfr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lpfr_out_if.sv =====
// ----------------------------------------------------------------------------
// lpfr_out_if: result channel
// Valid/ready channel carrying reply bytes and buffer read data.
// ----------------------------------------------------------------------------
interface lpfr_out_if import lpfr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lpfr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lpfr_cfg_if: configuration write channel
// Valid/ready channel carrying the handler-ready register value.
// ----------------------------------------------------------------------------
interface lpfr_cfg_if import lpfr_pkg::*; ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lpfr_ram.sv =====
// ----------------------------------------------------------------------------
// lpfr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lpfr_rx_fsm.sv =====
// ----------------------------------------------------------------------------
// lpfr_rx_fsm: frame reception control
// Tracks SOH, length bytes and payload fill, drives buffer writes and reads,
// and decides the ACK/NAK reply.
// ----------------------------------------------------------------------------
module lpfr_rx_fsm import lpfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  in_item_t          item_i,
  input  logic              handler_ready_i,
  output res_t              res_o,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [7:0]        wdata_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN_HIGH,
    PH_LEN_LOW,
    PH_ACTIVE
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [15:0]        len_q, len_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [FILL_W-1:0]  fill_inc;

  assign fill_inc = fill_q + FILL_W'(1);

  // Buffer write/read addressing
  assign waddr_o = fill_q[ADDR_W-1:0];
  assign wdata_o = item_i.rx_byte;
  assign raddr_o = ADDR_W'(item_i.read_index);

  // Next state and result decision
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    fill_d  = fill_q;
    we_o    = 1'b0;
    re_o    = 1'b0;
    res_o   = '0;
    if (accept_i) begin
      if (item_i.operation == OP_READ) begin
        re_o           = 1'b1;
        res_o.valid    = 1'b1;
        res_o.kind     = KIND_READ;
        res_o.in_range = (32'(item_i.read_index) < BUFFER_DEPTH);
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (item_i.rx_byte == SOH) begin
              phase_d = PH_LEN_HIGH;
            end
          end
          PH_LEN_HIGH: begin
            len_d   = {item_i.rx_byte, 8'h00};
            phase_d = PH_LEN_LOW;
          end
          PH_LEN_LOW: begin
            len_d   = {len_q[15:8], item_i.rx_byte};
            fill_d  = '0;
            phase_d = PH_ACTIVE;
          end
          PH_ACTIVE: begin
            // Store the byte; the last stored byte is the one just taken
            we_o   = 1'b1;
            fill_d = fill_inc;
            if (16'(fill_inc) == len_q) begin
              phase_d          = PH_IDLE;
              res_o.valid      = 1'b1;
              res_o.kind       = KIND_REPLY;
              if (item_i.rx_byte == EOT && handler_ready_i) begin
                res_o.reply_byte     = ACK;
                res_o.frame_accepted = 1'b1;
                res_o.frame_length   = len_q;
              end else begin
                res_o.reply_byte = NAK;
              end
            end else if (32'(fill_inc) >= BUFFER_DEPTH) begin
              // Buffer full before the count was reached
              phase_d          = PH_IDLE;
              res_o.valid      = 1'b1;
              res_o.kind       = KIND_REPLY;
              res_o.reply_byte = NAK;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= '0;
      fill_q  <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
    end
  end

endmodule

// ===== rtl/lpfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// lpfr_out_stage: result pipeline
// Holds a result while buffer read data arrives, then moves it into the
// output register; stalls the input only when both stages are blocked.
// ----------------------------------------------------------------------------
module lpfr_out_stage import lpfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_t       res_i,
  input  logic [7:0] rdata_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output out_item_t  out_item_o,
  input  logic       out_ready_i
);

  logic      s1_valid_q, s1_valid_d;
  res_t      s1_res_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      s1_move;

  // Stage one advances when the output register is free or being drained
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;

  // Next values
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (res_i.valid) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (s1_move) begin
      out_valid_d               = 1'b1;
      out_item_d.kind           = s1_res_q.kind;
      out_item_d.reply_byte     = s1_res_q.reply_byte;
      out_item_d.frame_accepted = s1_res_q.frame_accepted;
      out_item_d.frame_length   = s1_res_q.frame_length;
      out_item_d.read_data      = (s1_res_q.kind == KIND_READ && s1_res_q.in_range) ?
                                  rdata_i : 8'h00;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      s1_res_q <= res_i;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Both stages full and output stalled: no new transaction may enter
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while result pipeline is blocked");

  // A new result never lands on a held one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> in_ready_o)
    else $error("result produced while stage one cannot take it");

  // An accepted frame always answers ACK
  a_accept_is_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.frame_accepted |->
      out_item_q.kind == KIND_REPLY && out_item_q.reply_byte == ACK)
    else $error("frame accepted without ACK");

  // Refused frames carry no length
  a_nak_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_item_q.frame_accepted |-> out_item_q.frame_length == 16'h0000)
    else $error("length reported on a refused frame or read");

  // Read results carry no reply byte
  a_read_no_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.kind == KIND_READ |-> out_item_q.reply_byte == 8'h00)
    else $error("reply byte set on read data");

endmodule

// ===== rtl/length_prefixed_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_core: SOH/length/EOT frame receiver
// Receives serial bytes, buffers a length-prefixed frame and answers ACK/NAK.
// ----------------------------------------------------------------------------
// Usage
//   in_i   : one transaction per serial byte (operation 0) or per buffer read
//            (operation 1, read_index). Bytes in idle other than SOH are
//            dropped; the two length bytes (high first) produce no result.
//   out_o  : one transaction per completed or overflowed frame (reply byte
//            ACK or NAK, length on ACK) and one per buffer read.
//   cfg_i  : writes handler_ready; write only while the block is idle.
// Path: a result is held beside the buffer read data register in stage one,
//   then in the output register, before it appears on out_o.
// Throughput: one input transaction per cycle while out_o is ready; the
//   frame buffer's one write port and one registered read port serve one
//   item each cycle.
// Reset: control state returns to idle, handler_ready clears, the frame
//   buffer keeps whatever it held and is not cleared.
// Stall: when out_o is not ready, one result waits in the output register
//   and one more in the read stage; in_i.ready drops only when both are held.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_core import lpfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpfr_in_if.sink     in_i,
  lpfr_out_if.source  out_o,
  lpfr_cfg_if.sink    cfg_i
);

  logic              handler_ready_q;
  logic              in_ready;
  logic              accept;
  res_t              res;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      handler_ready_q <= 1'b0;
    end else if (cfg_i.valid) begin
      handler_ready_q <= cfg_i.data;
    end
  end

  // Reception control
  lpfr_rx_fsm u_rx_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .item_i          (in_i.data),
    .handler_ready_i (handler_ready_q),
    .res_o           (res),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .re_o            (re),
    .raddr_o         (raddr)
  );

  // Frame buffer
  lpfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result pipeline and output register
  lpfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .rdata_i     (rdata),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.data),
    .out_ready_i (out_o.ready)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the length-prefixed frame receiver
// Drives serial bytes and buffer reads with random gaps and output stalls.
// A scoreboard tracks SOH/length/body state, the frame buffer and the
// handler_ready register, and checks every reply and read against it.
// ----------------------------------------------------------------------------
module tb_top;
  import lpfr_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PIPE_LAT     = 4;
  localparam int MAX_GAP      = 13;
  localparam int ITEM_TARGET  = 1950;

  typedef enum logic [1:0] {PH_IDLE, PH_LEN_HI, PH_LEN_LO, PH_BODY} rx_phase_e;

  // Frame receiver scoreboard: receive state, buffer copy, pending results
  class frame_rx_scoreboard;
    bit          handler_ready;
    rx_phase_e   phase;
    logic [15:0] expected_len;
    int unsigned fill_cnt;
    logic [7:0]  frame_mem [BUFFER_DEPTH];
    bit          written [BUFFER_DEPTH];
    int unsigned written_cnt;
    out_item_t   pending_results [$];
    int unsigned mismatches;
    int unsigned n_ack;
    int unsigned n_nak;
    int unsigned n_read;

    function new();
      handler_ready = 1'b0;
      phase         = PH_IDLE;
      expected_len  = '0;
      fill_cnt      = 0;
      written_cnt   = 0;
      mismatches    = 0;
      n_ack         = 0;
      n_nak         = 0;
      n_read        = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // Advance the receive state by one accepted input transaction
    function void note_input(in_item_t it);
      out_item_t   res;
      int unsigned last_pos;
      res = '0;
      if (it.operation == OP_READ) begin
        res.kind      = KIND_READ;
        res.read_data = (int'(it.read_index) < BUFFER_DEPTH) ? frame_mem[it.read_index] : 8'h00;
        pending_results.push_back(res);
        n_read++;
        return;
      end
      case (phase)
        PH_IDLE: begin
          if (it.rx_byte == SOH) phase = PH_LEN_HI;
          return;
        end
        PH_LEN_HI: begin
          expected_len = {it.rx_byte, 8'h00};
          phase        = PH_LEN_LO;
          return;
        end
        PH_LEN_LO: begin
          expected_len = {expected_len[15:8], it.rx_byte};
          fill_cnt     = 0;
          phase        = PH_BODY;
          return;
        end
        default: ;
      endcase
      // body byte: store it, then look for count reached or buffer full
      if (fill_cnt < BUFFER_DEPTH) begin
        frame_mem[fill_cnt] = it.rx_byte;
        if (!written[fill_cnt]) begin
          written[fill_cnt] = 1'b1;
          written_cnt++;
        end
      end
      fill_cnt++;
      res.kind = KIND_REPLY;
      if (fill_cnt == expected_len) begin
        last_pos = (int'(expected_len) - 1) % BUFFER_DEPTH;
        phase    = PH_IDLE;
        if (frame_mem[last_pos] == EOT && handler_ready) begin
          res.reply_byte     = ACK;
          res.frame_accepted = 1'b1;
          res.frame_length   = expected_len;
          n_ack++;
        end else begin
          res.reply_byte = NAK;
          n_nak++;
        end
        pending_results.push_back(res);
      end else if (fill_cnt >= BUFFER_DEPTH) begin
        phase          = PH_IDLE;
        res.reply_byte = NAK;
        n_nak++;
        pending_results.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Check one result transaction against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("reply_byte", 16'(want.reply_byte), 16'(got.reply_byte));
      compare_field("frame_accepted", 16'(want.frame_accepted), 16'(got.frame_accepted));
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
    endfunction

    // Random position among those written so far, or -1 when none is
    function int pick_written_index();
      int start;
      start = $urandom_range(0, BUFFER_DEPTH - 1);
      for (int k = 0; k < BUFFER_DEPTH; k++) begin
        if (written[(start + k) % BUFFER_DEPTH]) return (start + k) % BUFFER_DEPTH;
      end
      return -1;
    endfunction

    function void report_leftovers();
      if (pending_results.size() != 0) begin
        mismatches += pending_results.size();
        $display("%0t: results missing, expected %0d more, actual 0", $time,
                 pending_results.size());
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   no_idle;
  int unsigned items_sent;
  int unsigned n_cfg;
  frame_rx_scoreboard sb = new();

  lpfr_in_if  in_bus ();
  lpfr_out_if out_bus ();
  lpfr_cfg_if cfg_bus ();

  length_prefixed_frame_receiver_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // One input transaction: optional gap, then hold valid until accepted
  task automatic send_item(in_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= it;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_rx(logic [7:0] b);
    in_item_t it;
    it.operation  = OP_RX;
    it.rx_byte    = b;
    it.read_index = 9'($urandom_range(0, 511));
    send_item(it);
  endtask

  // Buffer read; a negative position picks any written one
  task automatic send_read(int pos);
    in_item_t it;
    if (pos < 0) pos = sb.pick_written_index();
    if (pos < 0) return;
    it.operation  = OP_READ;
    it.rx_byte    = 8'($urandom_range(0, 255));
    it.read_index = 9'(pos);
    send_item(it);
  endtask

  // SOH, length field, then n_data body bytes with reads mixed in
  task automatic send_frame(logic [15:0] len_field, int n_data, bit eot_last, int read_pct);
    logic [7:0] b;
    send_rx(SOH);
    send_rx(len_field[15:8]);
    send_rx(len_field[7:0]);
    for (int i = 0; i < n_data; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == n_data - 1) begin
        if (eot_last) b = EOT;
        else if (b == EOT) b = 8'hFF;
      end
      send_rx(b);
      if ($urandom_range(0, 99) < read_pct) send_read(-1);
    end
  endtask

  // Hold off the sender until every expected result is back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  task automatic write_handler_ready(bit v);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid     <= 1'b0;
    sb.handler_ready  = v;
    n_cfg++;
  endtask

  // Result sink with random stalls
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      sb.check_result(out_bus.data);
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    int          sel;
    int          len;
    int          n;
    int unsigned next_cfg;
    logic [7:0]  b;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = 1'b0;
    rst_ni        = 1'b0;
    no_idle       = 1'b0;
    items_sent    = 0;
    n_cfg         = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle noise, then a good frame with no handler attached
    send_rx(8'hFF);
    send_rx(8'h00);
    send_frame(16'h0001, 1, 1'b1, 0);
    write_handler_ready(1'b1);
    send_frame(16'h0003, 3, 1'b1, 0);
    send_read(0);
    send_read(1);
    send_read(2);
    // frame ending in a non-EOT byte, with a read in the middle
    send_rx(SOH);
    send_rx(8'h00);
    send_rx(8'h02);
    send_rx(EOT);
    send_read(0);
    send_rx(8'hFF);

    // long frames: exact fit, zero length and oversize length
    send_frame(16'h0200, BUFFER_DEPTH, 1'b1, 2);
    send_frame(16'h0000, BUFFER_DEPTH, 1'b0, 1);
    send_frame(16'hFFFF, BUFFER_DEPTH, 1'b1, 1);
    write_handler_ready(1'b0);

    // random traffic, mostly well-formed frames
    next_cfg = items_sent + 100;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_cfg && sb.phase == PH_IDLE) begin
        write_handler_ready(1'($urandom_range(0, 1)));
        next_cfg += 200 + $urandom_range(0, 200);
      end
      if ($urandom_range(0, 99) < 3) no_idle = !no_idle;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        b = 8'($urandom_range(0, 255));
        if (b == SOH) b = 8'h02;
        send_rx(b);
      end else if (sel < 16) begin
        n = $urandom_range(1, 4);
        repeat (n) send_read(-1);
      end else if (sel < 24) begin
        // truncated or overrun body
        len = $urandom_range(1, 24);
        n   = ($urandom_range(0, 1) != 0) ? $urandom_range(0, len - 1)
                                          : len + $urandom_range(1, 4);
        send_frame(16'(len), n, 1'($urandom_range(0, 1)), 5);
      end else begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 255) : $urandom_range(1, 24);
        send_frame(16'(len), len, $urandom_range(0, 99) < 85, 10);
      end
    end

    wait_drained();
    sb.report_leftovers();
    $display("Covered %0d ACK and %0d NAK replies, %0d buffer reads, %0d handler_ready writes",
             sb.n_ack, sb.n_nak, sb.n_read, n_cfg);
    $display("Sent %0d input transactions in all, three full-buffer frames among them",
             items_sent);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== length_prefixed_frame_receiver_core.f =====
rtl/lpfr_pkg.sv
rtl/lpfr_in_if.sv
rtl/lpfr_out_if.sv
rtl/lpfr_cfg_if.sv
rtl/lpfr_ram.sv
rtl/lpfr_rx_fsm.sv
rtl/lpfr_out_stage.sv
rtl/length_prefixed_frame_receiver_core.sv
dv/tb_top.sv
